/* hw/rtl/opm_pkg.sv */
`timescale 1ns / 1ps

package opm_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int PAT_CHARS       = 16;
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 5;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int DIR_W           = 2;
    localparam int OUT_TDATA_W     = 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [DIR_W-1:0]     t_dir;

    localparam t_cfg_idx REG_FIRST_LO  = 3'd0;
    localparam t_cfg_idx REG_FIRST_HI  = 3'd1;
    localparam t_cfg_idx REG_SECOND_LO = 3'd2;
    localparam t_cfg_idx REG_SECOND_HI = 3'd3;
    localparam t_cfg_idx REG_FIRST_LEN = 3'd4;
    localparam t_cfg_idx REG_SECOND_LEN = 3'd5;

    localparam t_dir DIR_FORWARD  = 2'd0;
    localparam t_dir DIR_BACKWARD = 2'd1;
    localparam t_dir DIR_BOTH     = 2'd2;
    localparam t_dir DIR_INVALID  = 2'd3;

    typedef logic [PAT_CHARS-1:0][CHAR_W-1:0] t_pattern;

    typedef struct packed {
        t_pattern          first_pat;
        t_pattern          second_pat;
        logic [LEN_W-1:0]  first_len;
        logic [LEN_W-1:0]  second_len;
    } t_cfg;

endpackage

/* hw/rtl/opm_cfg_regs.sv */
`timescale 1ns / 1ps

module opm_cfg_regs
    import opm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [CFG_DATA_W-1:0] r_first_lo;
    logic [CFG_DATA_W-1:0] r_first_hi;
    logic [CFG_DATA_W-1:0] r_second_lo;
    logic [CFG_DATA_W-1:0] r_second_hi;
    logic [LEN_W-1:0]      r_first_len;
    logic [LEN_W-1:0]      r_second_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_lo   <= '0;
            r_first_hi   <= '0;
            r_second_lo  <= '0;
            r_second_hi  <= '0;
            r_first_len  <= LEN_W'(1);
            r_second_len <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FIRST_LO:   r_first_lo   <= i_cfg_data;
                REG_FIRST_HI:   r_first_hi   <= i_cfg_data;
                REG_SECOND_LO:  r_second_lo  <= i_cfg_data;
                REG_SECOND_HI:  r_second_hi  <= i_cfg_data;
                REG_FIRST_LEN:  r_first_len  <= i_cfg_data[LEN_W-1:0];
                REG_SECOND_LEN: r_second_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.first_pat  = {r_first_hi, r_first_lo};
    assign o_cfg.second_pat = {r_second_hi, r_second_lo};
    assign o_cfg.first_len  = r_first_len;
    assign o_cfg.second_len = r_second_len;

endmodule

/* hw/rtl/opm_window_cmp.sv */
`timescale 1ns / 1ps

module opm_window_cmp
    import opm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic [MAX_PATTERN-1:0][CHAR_W-1:0]       i_window,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]         i_count,
    input  t_pattern                                 i_pattern,
    input  logic [LEN_W-1:0]                         i_len,
    input  logic                                     i_rev,
    output logic                                     o_match
);

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [LEN_W-1:0] w_idx [MAX_PATTERN];
    logic             w_eq  [MAX_PATTERN];

    // pattern char k sits at window entry len-1-k (forward) or k (reversed);
    // entry 0 is the newest character
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            w_idx[k] = i_rev ? LEN_W'(k) : (i_len - LEN_W'(1) - LEN_W'(k));
            w_eq[k]  = (LEN_W'(k) >= i_len) ||
                       (i_pattern[k] == i_window[w_idx[k][IW-1:0]]);
        end
    end

    always_comb begin
        o_match = (i_len != '0) && (LEN_W'(i_count) >= i_len);
        for (int k = 0; k < MAX_PATTERN; k++) begin
            o_match = o_match & w_eq[k];
        end
    end

endmodule

/* hw/rtl/opm_order_track.sv */
`timescale 1ns / 1ps

module opm_order_track
    import opm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_clear,
    input  logic             i_lead_match,
    input  logic             i_trail_match,
    input  logic [LEN_W-1:0] i_trail_len,
    output logic             o_found_next
);

    localparam int CW = $clog2(MAX_PATTERN + 1);

    logic          r_seen;
    logic [CW-1:0] r_since;
    logic          r_found;
    logic          n_seen;
    logic [CW-1:0] n_since;
    logic [CW-1:0] w_since_inc;

    // distance is counted from the earliest lead occurrence only
    always_comb begin
        w_since_inc = (r_seen && (r_since < CW'(MAX_PATTERN))) ? r_since + CW'(1) : r_since;
        o_found_next = r_found ||
                       (r_seen && i_trail_match && (LEN_W'(w_since_inc) >= i_trail_len));
        n_seen  = r_seen;
        n_since = w_since_inc;
        if (!r_seen && i_lead_match) begin
            n_seen  = 1'b1;
            n_since = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_since <= '0;
            r_found <= 1'b0;
        end else if (i_step) begin
            if (i_clear) begin
                r_seen  <= 1'b0;
                r_since <= '0;
                r_found <= 1'b0;
            end else begin
                r_seen  <= n_seen;
                r_since <= n_since;
                r_found <= o_found_next;
            end
        end
    end

endmodule

/* hw/rtl/ordered_pattern_pair_match_bidir_unit.sv */
`timescale 1ns / 1ps

// Ordered two-pattern matcher over a character stream.
// Input channel (s_axis): one text character per transaction in tdata[7:0];
// tlast marks the final character of a text. Output channel (m_axis): one
// transaction per text, sent for its last character, tdata[1:0] = direction
// (0 forward, 1 backward, 2 both, 3 invalid).
// Patterns and lengths (cfg port, index 0..5; other indexes are dropped) must
// be written while no text is in flight; the block does not enforce this.
// Throughput: one character per cycle unless the output stalls. The window
// shift, the four parallel window compares and the order trackers all update
// in the accept cycle. Latency: the result is registered, so m_axis_tvalid
// rises the cycle after the last character is accepted.
// When the receiver stalls, the result stays in the output register and
// s_axis_tready is low until m_axis_tready returns; a new transaction can be
// accepted in the same cycle the held result is taken.
// Reset (synchronous, active low) empties the output register, clears the
// window and trackers, sets patterns to zero and both lengths to one.
module ordered_pattern_pair_match_bidir_unit
    import opm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  t_cfg_idx               i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [CHAR_W-1:0]      s_axis_tdata,   // [7:0] text_char
    input  logic                   s_axis_tlast,   // text_end
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [1:0] direction, rest zero
);

    localparam int CW = $clog2(MAX_PATTERN + 1);

    t_cfg                              w_cfg;
    logic [MAX_PATTERN-1:0][CHAR_W-1:0] r_window;
    logic [MAX_PATTERN-1:0][CHAR_W-1:0] n_window;
    logic [CW-1:0]                     r_seen_cnt;
    logic [CW-1:0]                     n_seen_cnt;
    logic [LEN_W-1:0]                  w_len1;
    logic [LEN_W-1:0]                  w_len2;
    logic                              w_m1, w_m2, w_r1, w_r2;
    logic                              w_fwd, w_bwd;
    logic                              w_acc;
    logic                              r_out_valid;
    t_dir                              r_dir;
    t_dir                              n_dir;

    opm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    assign w_len1 = (w_cfg.first_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                             : w_cfg.first_len;
    assign w_len2 = (w_cfg.second_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                              : w_cfg.second_len;

    // compares run on the window as it stands after taking this character
    always_comb begin
        n_window[0] = s_axis_tdata;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            n_window[i] = r_window[i-1];
        end
        n_seen_cnt = (r_seen_cnt < CW'(MAX_PATTERN)) ? r_seen_cnt + CW'(1) : r_seen_cnt;
    end

    opm_window_cmp #(.MAX_PATTERN(MAX_PATTERN)) u_cmp_m1 (
        .i_window (n_window), .i_count (n_seen_cnt), .i_pattern (w_cfg.first_pat),
        .i_len (w_len1), .i_rev (1'b0), .o_match (w_m1)
    );

    opm_window_cmp #(.MAX_PATTERN(MAX_PATTERN)) u_cmp_m2 (
        .i_window (n_window), .i_count (n_seen_cnt), .i_pattern (w_cfg.second_pat),
        .i_len (w_len2), .i_rev (1'b0), .o_match (w_m2)
    );

    opm_window_cmp #(.MAX_PATTERN(MAX_PATTERN)) u_cmp_r1 (
        .i_window (n_window), .i_count (n_seen_cnt), .i_pattern (w_cfg.first_pat),
        .i_len (w_len1), .i_rev (1'b1), .o_match (w_r1)
    );

    opm_window_cmp #(.MAX_PATTERN(MAX_PATTERN)) u_cmp_r2 (
        .i_window (n_window), .i_count (n_seen_cnt), .i_pattern (w_cfg.second_pat),
        .i_len (w_len2), .i_rev (1'b1), .o_match (w_r2)
    );

    opm_order_track #(.MAX_PATTERN(MAX_PATTERN)) u_fwd (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_step (w_acc), .i_clear (s_axis_tlast),
        .i_lead_match (w_m1), .i_trail_match (w_m2), .i_trail_len (w_len2),
        .o_found_next (w_fwd)
    );

    // backward: reversed second pattern leads, reversed first trails
    opm_order_track #(.MAX_PATTERN(MAX_PATTERN)) u_bwd (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_step (w_acc), .i_clear (s_axis_tlast),
        .i_lead_match (w_r2), .i_trail_match (w_r1), .i_trail_len (w_len1),
        .o_found_next (w_bwd)
    );

    always_comb begin
        if (w_fwd && w_bwd) begin
            n_dir = DIR_BOTH;
        end else if (w_fwd) begin
            n_dir = DIR_FORWARD;
        end else if (w_bwd) begin
            n_dir = DIR_BACKWARD;
        end else begin
            n_dir = DIR_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= '0;
            r_seen_cnt <= '0;
        end else if (w_acc) begin
            if (s_axis_tlast) begin
                r_window   <= '0;
                r_seen_cnt <= '0;
            end else begin
                r_window   <= n_window;
                r_seen_cnt <= n_seen_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && s_axis_tlast) begin
            r_dir <= n_dir;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - DIR_W){1'b0}}, r_dir};

endmodule
